FILE: rtl/core/cct_pkg.sv
// ----------------------------------------------------------------------------
// cct_pkg
// Types, codes and helper functions shared by the tokenizer files.
// ----------------------------------------------------------------------------
package cct_pkg;

	localparam int POS_WIDTH = 16;
	localparam int QUEUE_DEPTH = 8;
	localparam int QUEUE_AW = $clog2(QUEUE_DEPTH);
	localparam int MAX_PER_BYTE = 3;

	typedef logic [POS_WIDTH-1:0] pos_t;
	typedef logic [15:0] count_t;

	localparam pos_t POS_MAX = '1;
	localparam count_t COUNT_MAX = '1;
	localparam count_t CAPACITY_RESET = 16'd256;

	localparam logic [7:0] CJK_LO = 8'hE4;
	localparam logic [7:0] CJK_HI = 8'hE9;
	localparam logic [7:0] CHAR_HYPHEN = 8'h2D;
	localparam logic [7:0] CHAR_DOT = 8'h2E;
	localparam logic [7:0] CHAR_APOS = 8'h27;
	localparam logic [7:0] CHAR_END = 8'h00;

	typedef enum logic [2:0] {
		KIND_WS   = 3'd0,
		KIND_WORD = 3'd1,
		KIND_NUM  = 3'd2,
		KIND_CJK  = 3'd3,
		KIND_SYM  = 3'd4,
		KIND_NONE = 3'd7
	} kind_t;

	typedef enum logic [1:0] {
		JOIN_NONE   = 2'd0,
		JOIN_APOS   = 2'd1,
		JOIN_HYPHEN = 2'd2,
		JOIN_DOT    = 2'd3
	} joiner_t;

	typedef struct packed {
		logic [2:0] token_kind;
		pos_t       start_pos;
		pos_t       end_pos;
		logic       end_of_text;
		count_t     token_total;
	} result_t;

	typedef struct packed {
		logic [1:0]                    n;
		result_t [MAX_PER_BYTE-1:0]    item;
	} push_t;

	function automatic logic is_letter(logic [7:0] c);
		return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
	endfunction

	function automatic logic is_digit(logic [7:0] c);
		return c >= 8'h30 && c <= 8'h39;
	endfunction

	function automatic logic is_space(logic [7:0] c);
		return c == 8'h20 || (c >= 8'h09 && c <= 8'h0D);
	endfunction

	function automatic pos_t sat_inc(pos_t p);
		return (p == POS_MAX) ? p : p + pos_t'(1);
	endfunction

	function automatic count_t count_inc(count_t c);
		return (c == COUNT_MAX) ? c : c + count_t'(1);
	endfunction

	function automatic result_t make_token(kind_t kind, pos_t s, pos_t e);
		result_t r;
		r.token_kind  = kind;
		r.start_pos   = s;
		r.end_pos     = e;
		r.end_of_text = 1'b0;
		r.token_total = '0;
		return r;
	endfunction

endpackage

FILE: rtl/core/cct_byte_if.sv
// ----------------------------------------------------------------------------
// cct_byte_if
// Text byte channel with valid/ready handshake.
// ----------------------------------------------------------------------------
interface cct_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] text_byte;

	modport source (output valid, output text_byte, input ready);
	modport sink (input valid, input text_byte, output ready);
endinterface

FILE: rtl/core/cct_token_if.sv
// ----------------------------------------------------------------------------
// cct_token_if
// Token result channel with valid/ready handshake.
// ----------------------------------------------------------------------------
interface cct_token_if;
	logic        valid;
	logic        ready;
	logic [2:0]  token_kind;
	logic [15:0] start_pos;
	logic [15:0] end_pos;
	logic        end_of_text;
	logic [15:0] token_total;

	modport source (output valid, output token_kind, output start_pos, output end_pos,
		output end_of_text, output token_total, input ready);
	modport sink (input valid, input token_kind, input start_pos, input end_pos,
		input end_of_text, input token_total, output ready);
endinterface

FILE: rtl/core/cct_cfg_if.sv
// ----------------------------------------------------------------------------
// cct_cfg_if
// Configuration write channel carrying the token capacity.
// ----------------------------------------------------------------------------
interface cct_cfg_if;
	logic        valid;
	logic        ready;
	logic [15:0] token_capacity;

	modport source (output valid, output token_capacity, input ready);
	modport sink (input valid, input token_capacity, output ready);
endinterface

FILE: rtl/core/char_class_tokenizer_unit.sv
// ----------------------------------------------------------------------------
// char_class_tokenizer_unit
// Streaming byte tokenizer: text bytes in, tokens and a closing count out.
//
// The text channel takes one byte per transfer; a zero byte ends the text.
// The tokens channel gives one result per transfer: a token with its kind,
// start and end position, or the closing item of a text with the count.
// The cfg channel writes the token capacity; it is always ready and should
// be written only while no text is in flight.
// A byte is registered at its transfer and is processed once the queue has
// room; the byte may close up to three results, which enter an eight-entry
// queue and are visible in the cycle after they are written. Tokens close
// on a later byte, so output lags input.
// The block takes one byte per cycle while the queue has room for three
// results, so when the receiver stalls or bytes close several results at
// once, the text channel drops ready once more than five results wait in
// the queue. At reset the queue empties, the tokenizer returns to the
// start of a text and the capacity returns to 256.
// ----------------------------------------------------------------------------
module char_class_tokenizer_unit (
	input  logic        clk,
	input  logic        arst_n,
	cct_byte_if.sink    text,
	cct_token_if.source tokens,
	cct_cfg_if.sink     cfg
);
	import cct_pkg::*;

	count_t capacity_q;
	push_t  push;
	logic   room;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= CAPACITY_RESET;
		end else if (cfg.valid) begin
			capacity_q <= cfg.token_capacity;
		end
	end

	cct_core u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.text     (text),
		.capacity (capacity_q),
		.room     (room),
		.push     (push)
	);

	cct_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.room   (room),
		.tokens (tokens)
	);

endmodule

FILE: rtl/core/cct_core.sv
// ----------------------------------------------------------------------------
// cct_core
// Input register, per-text tokenizer state and the single-pass step logic
// that turns one byte into up to three results.
// ----------------------------------------------------------------------------
module cct_core (
	input  logic            clk,
	input  logic            arst_n,
	cct_byte_if.sink        text,
	input  cct_pkg::count_t capacity,
	input  logic            room,
	output cct_pkg::push_t  push
);
	import cct_pkg::*;

	logic [7:0] byte_s1;
	logic       valid_s1;
	logic       fire;

	kind_t   kind_q;
	joiner_t join_q;
	pos_t    jpos_q;
	pos_t    start_q;
	pos_t    pos_q;
	logic [1:0] cjk_q;
	count_t  count_q;

	kind_t   kind_d;
	joiner_t join_d;
	pos_t    jpos_d;
	pos_t    start_d;
	pos_t    pos_d;
	logic [1:0] cjk_d;
	count_t  count_d;

	result_t    res [MAX_PER_BYTE];
	logic [1:0] k;

	assign fire = valid_s1 && room;
	assign text.ready = !valid_s1 || room;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (text.ready) begin
			valid_s1 <= text.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (text.ready && text.valid) begin
			byte_s1 <= text.text_byte;
		end
	end

	always_comb begin
		logic [7:0] c;
		logic       done;
		logic       goes;
		count_t     cnt;
		logic [1:0] left;

		c = byte_s1;
		done = 1'b0;
		goes = 1'b0;
		cnt = count_q;
		left = cjk_q;
		k = '0;
		for (int i = 0; i < MAX_PER_BYTE; i++) begin
			res[i] = '0;
		end
		kind_d = kind_q;
		join_d = join_q;
		jpos_d = jpos_q;
		start_d = start_q;
		cjk_d = cjk_q;
		pos_d = sat_inc(pos_q);
		count_d = count_q;

		if (c == CHAR_END) begin
			if (join_q != JOIN_NONE) begin
				res[k] = make_token(kind_q, start_q, jpos_q);
				k = k + 2'd1;
				cnt = count_inc(cnt);
				if (cnt < capacity) begin
					res[k] = make_token(KIND_SYM, jpos_q, sat_inc(jpos_q));
					k = k + 2'd1;
					cnt = count_inc(cnt);
				end
			end else if (kind_q != KIND_NONE) begin
				res[k] = make_token(kind_q, start_q, pos_q);
				k = k + 2'd1;
				cnt = count_inc(cnt);
			end
			res[k].token_kind = KIND_WS;
			res[k].start_pos = '0;
			res[k].end_pos = pos_q;
			res[k].end_of_text = 1'b1;
			res[k].token_total = cnt;
			k = k + 2'd1;
			kind_d = KIND_NONE;
			join_d = JOIN_NONE;
			jpos_d = '0;
			start_d = '0;
			pos_d = '0;
			cjk_d = '0;
			cnt = '0;
			done = 1'b1;
		end else begin
			if (join_q != JOIN_NONE) begin
				goes = (kind_q == KIND_WORD) ? is_letter(c) : is_digit(c);
				join_d = JOIN_NONE;
				if (goes) begin
					done = 1'b1;
				end else begin
					res[k] = make_token(kind_q, start_q, jpos_q);
					k = k + 2'd1;
					cnt = count_inc(cnt);
					kind_d = KIND_NONE;
					if (cnt < capacity) begin
						res[k] = make_token(KIND_SYM, jpos_q, sat_inc(jpos_q));
						k = k + 2'd1;
						cnt = count_inc(cnt);
					end
				end
			end else if (kind_q == KIND_CJK) begin
				if (left != 2'd0) begin
					left = left - 2'd1;
				end
				cjk_d = left;
				if (left == 2'd0) begin
					res[k] = make_token(KIND_CJK, start_q, sat_inc(pos_q));
					k = k + 2'd1;
					cnt = count_inc(cnt);
					kind_d = KIND_NONE;
				end
				done = 1'b1;
			end else if (kind_q != KIND_NONE) begin
				case (kind_q)
					KIND_WS: begin
						goes = is_space(c);
					end
					KIND_WORD: begin
						goes = is_letter(c);
						if (c == CHAR_APOS) begin
							join_d = JOIN_APOS;
							goes = 1'b1;
						end else if (c == CHAR_HYPHEN) begin
							join_d = JOIN_HYPHEN;
							goes = 1'b1;
						end
					end
					default: begin
						goes = is_digit(c);
						if (c == CHAR_DOT) begin
							join_d = JOIN_DOT;
							goes = 1'b1;
						end
					end
				endcase
				if (join_d != JOIN_NONE) begin
					jpos_d = pos_q;
				end
				if (goes) begin
					done = 1'b1;
				end else begin
					res[k] = make_token(kind_q, start_q, pos_q);
					k = k + 2'd1;
					cnt = count_inc(cnt);
					kind_d = KIND_NONE;
				end
			end

			if (!done && cnt < capacity) begin
				start_d = pos_q;
				if (is_space(c)) begin
					kind_d = KIND_WS;
				end else if (is_letter(c)) begin
					kind_d = KIND_WORD;
				end else if (is_digit(c)) begin
					kind_d = KIND_NUM;
				end else if (c >= CJK_LO && c <= CJK_HI) begin
					kind_d = KIND_CJK;
					cjk_d = 2'd2;
				end else begin
					res[k] = make_token(KIND_SYM, pos_q, sat_inc(pos_q));
					k = k + 2'd1;
					cnt = count_inc(cnt);
				end
			end
		end
		count_d = cnt;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kind_q <= KIND_NONE;
			join_q <= JOIN_NONE;
			jpos_q <= '0;
			start_q <= '0;
			pos_q <= '0;
			cjk_q <= '0;
			count_q <= '0;
		end else if (fire) begin
			kind_q <= kind_d;
			join_q <= join_d;
			jpos_q <= jpos_d;
			start_q <= start_d;
			pos_q <= pos_d;
			cjk_q <= cjk_d;
			count_q <= count_d;
		end
	end

	always_comb begin
		push.n = fire ? k : 2'd0;
		for (int i = 0; i < MAX_PER_BYTE; i++) begin
			push.item[i] = res[i];
		end
	end

endmodule

FILE: rtl/core/cct_queue.sv
// ----------------------------------------------------------------------------
// cct_queue
// Eight-entry result queue that takes up to three results per cycle and
// delivers one per transfer on the token channel.
// ----------------------------------------------------------------------------
module cct_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  cct_pkg::push_t push,
	output logic           room,
	cct_token_if.source    tokens
);
	import cct_pkg::*;

	result_t mem_q [QUEUE_DEPTH];
	logic [QUEUE_AW-1:0] head_q;
	logic [QUEUE_AW-1:0] tail_q;
	logic [QUEUE_AW:0]   count_q;
	logic                pop;
	result_t             head_item;

	assign pop = tokens.valid && tokens.ready;
	assign room = count_q <= (QUEUE_AW + 1)'(QUEUE_DEPTH - MAX_PER_BYTE);

	always_ff @(posedge clk) begin
		if (push.n > 2'd0) begin
			mem_q[tail_q] <= push.item[0];
		end
		if (push.n > 2'd1) begin
			mem_q[tail_q + QUEUE_AW'(1)] <= push.item[1];
		end
		if (push.n > 2'd2) begin
			mem_q[tail_q + QUEUE_AW'(2)] <= push.item[2];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			tail_q <= '0;
			count_q <= '0;
		end else begin
			tail_q <= tail_q + QUEUE_AW'(push.n);
			if (pop) begin
				head_q <= head_q + QUEUE_AW'(1);
			end
			count_q <= count_q + (QUEUE_AW + 1)'(push.n) - (QUEUE_AW + 1)'(pop);
		end
	end

	assign head_item = mem_q[head_q];
	assign tokens.valid = count_q != '0;
	assign tokens.token_kind = head_item.token_kind;
	assign tokens.start_pos = head_item.start_pos[15:0];
	assign tokens.end_pos = head_item.end_pos[15:0];
	assign tokens.end_of_text = head_item.end_of_text;
	assign tokens.token_total = head_item.token_total;

endmodule

FILE: tb/sv/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking testbench for the streaming character class tokenizer.
//
// A directed table of short texts comes first. It covers the empty text,
// joined and broken joiners, full and cut-short CJK tokens, and a byte that
// closes three tokens at once. Random texts follow, built from words,
// numbers, spaces and CJK groups, with broken joiners and noise mixed in.
// They run under several token capacities, from zero up to the maximum.
// Every accepted text byte goes through a behavioral predictor, and each
// token transfer is compared field by field with the oldest prediction.
// Each side inserts random idle cycles in some phases and runs at full rate in others.
// ----------------------------------------------------------------------------
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import cct_pkg::*;

	localparam int IDLE_LIMIT = 500;
	localparam int SETTLE_CYCLES = 8;
	localparam int PHASE_BYTES = 36;

	typedef struct packed {
		logic [7:0] text_byte;
		logic       typed;
		result_t    last_token;
	} directed_row_t;

	logic clk;
	logic arst_n;

	cct_byte_if  text_ch ();
	cct_token_if token_ch ();
	cct_cfg_if   cfg_ch ();

	char_class_tokenizer_unit dut (
		.clk    (clk),
		.arst_n (arst_n),
		.text   (text_ch),
		.tokens (token_ch),
		.cfg    (cfg_ch)
	);

	result_t expected_tokens[$];

	kind_t   open_kind;
	joiner_t open_joiner;
	pos_t    joiner_at;
	pos_t    run_start;
	pos_t    byte_pos;
	logic [1:0] cjk_left;
	count_t  token_count;
	count_t  capacity;

	int  mismatches = 0;
	int  bytes_sent = 0;
	int  texts_sent = 0;
	int  tokens_checked = 0;
	int  idle_cycles = 0;
	bit  sender_idles = 1'b1;
	bit  receiver_idles = 1'b1;

	directed_row_t directed_rows [22] = '{
		'{8'h00, 1'b1, '{KIND_WS, 16'd0, 16'd0, 1'b1, 16'd0}},
		'{8'h49, 1'b0, '0},
		'{8'h27, 1'b0, '0},
		'{8'h6D, 1'b0, '0},
		'{8'h20, 1'b0, '0},
		'{8'h09, 1'b0, '0},
		'{8'h37, 1'b0, '0},
		'{8'h2E, 1'b0, '0},
		'{8'h35, 1'b0, '0},
		'{8'h2E, 1'b0, '0},
		'{8'h78, 1'b0, '0},
		'{8'h2D, 1'b0, '0},
		'{8'h3B, 1'b0, '0},
		'{8'hE4, 1'b0, '0},
		'{8'hFF, 1'b0, '0},
		'{8'h80, 1'b0, '0},
		'{8'hE9, 1'b0, '0},
		'{8'h00, 1'b0, '0},
		'{8'hFF, 1'b1, '{KIND_SYM, 16'd0, 16'd1, 1'b0, 16'd0}},
		'{8'h7A, 1'b0, '0},
		'{8'h27, 1'b0, '0},
		'{8'h00, 1'b1, '{KIND_WS, 16'd0, 16'd3, 1'b1, 16'd3}}
	};

	function automatic pos_t pos_next(pos_t p);
		return (p == '1) ? p : p + pos_t'(1);
	endfunction

	function automatic logic letter_byte(logic [7:0] b);
		return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z");
	endfunction

	function automatic logic digit_byte(logic [7:0] b);
		return b >= "0" && b <= "9";
	endfunction

	function automatic logic space_byte(logic [7:0] b);
		return b == 8'h20 || (b >= 8'h09 && b <= 8'h0D);
	endfunction

	function automatic logic [7:0] any_letter();
		return $urandom_range(0, 1) ? 8'("a" + $urandom_range(0, 25))
			: 8'("A" + $urandom_range(0, 25));
	endfunction

	function automatic logic [7:0] any_digit();
		return 8'("0" + $urandom_range(0, 9));
	endfunction

	function automatic logic [7:0] any_space();
		int pick;
		pick = $urandom_range(0, 5);
		return (pick == 5) ? 8'h20 : 8'(8'h09 + pick);
	endfunction

	task automatic restart_text();
		open_kind = KIND_NONE;
		open_joiner = JOIN_NONE;
		joiner_at = '0;
		run_start = '0;
		byte_pos = '0;
		cjk_left = '0;
		token_count = '0;
	endtask

	task automatic push_token(kind_t kind, pos_t s, pos_t e);
		result_t r;
		r.token_kind = kind;
		r.start_pos = s;
		r.end_pos = e;
		r.end_of_text = 1'b0;
		r.token_total = '0;
		expected_tokens.push_back(r);
		if (token_count != '1)
			token_count++;
	endtask

	task automatic tokenize_byte(logic [7:0] b);
		pos_t    p;
		logic    goes_on;
		logic    take_new;
		result_t closing;
		p = byte_pos;
		if (b == CHAR_END) begin
			if (open_joiner != JOIN_NONE) begin
				push_token(open_kind, run_start, joiner_at);
				if (token_count < capacity)
					push_token(KIND_SYM, joiner_at, pos_next(joiner_at));
			end else if (open_kind != KIND_NONE) begin
				push_token(open_kind, run_start, p);
			end
			closing.token_kind = KIND_WS;
			closing.start_pos = '0;
			closing.end_pos = p;
			closing.end_of_text = 1'b1;
			closing.token_total = token_count;
			expected_tokens.push_back(closing);
			restart_text();
		end else begin
			take_new = 1'b1;
			if (open_joiner != JOIN_NONE) begin
				goes_on = (open_kind == KIND_WORD) ? letter_byte(b) : digit_byte(b);
				open_joiner = JOIN_NONE;
				if (goes_on) begin
					take_new = 1'b0;
				end else begin
					push_token(open_kind, run_start, joiner_at);
					open_kind = KIND_NONE;
					if (token_count < capacity)
						push_token(KIND_SYM, joiner_at, pos_next(joiner_at));
				end
			end else if (open_kind == KIND_CJK) begin
				take_new = 1'b0;
				if (cjk_left != 0)
					cjk_left--;
				if (cjk_left == 0) begin
					push_token(KIND_CJK, run_start, pos_next(p));
					open_kind = KIND_NONE;
				end
			end else if (open_kind != KIND_NONE) begin
				case (open_kind)
					KIND_WS: begin
						goes_on = space_byte(b);
					end
					KIND_WORD: begin
						goes_on = letter_byte(b);
						if (b == CHAR_APOS) begin
							open_joiner = JOIN_APOS;
							goes_on = 1'b1;
						end else if (b == CHAR_HYPHEN) begin
							open_joiner = JOIN_HYPHEN;
							goes_on = 1'b1;
						end
					end
					default: begin
						goes_on = digit_byte(b);
						if (b == CHAR_DOT) begin
							open_joiner = JOIN_DOT;
							goes_on = 1'b1;
						end
					end
				endcase
				if (open_joiner != JOIN_NONE)
					joiner_at = p;
				if (goes_on) begin
					take_new = 1'b0;
				end else begin
					push_token(open_kind, run_start, p);
					open_kind = KIND_NONE;
				end
			end
			if (take_new && token_count < capacity) begin
				run_start = p;
				if (space_byte(b)) begin
					open_kind = KIND_WS;
				end else if (letter_byte(b)) begin
					open_kind = KIND_WORD;
				end else if (digit_byte(b)) begin
					open_kind = KIND_NUM;
				end else if (b >= CJK_LO && b <= CJK_HI) begin
					open_kind = KIND_CJK;
					cjk_left = 2'd2;
				end else begin
					push_token(KIND_SYM, p, pos_next(p));
				end
			end
			byte_pos = pos_next(p);
		end
	endtask

	task automatic check_token(result_t want, result_t got);
		if (want.token_kind !== got.token_kind) begin
			$error("token_kind: expected %0d, got %0d", want.token_kind, got.token_kind);
			mismatches++;
		end
		if (want.start_pos !== got.start_pos) begin
			$error("start_pos: expected %0d, got %0d", want.start_pos, got.start_pos);
			mismatches++;
		end
		if (want.end_pos !== got.end_pos) begin
			$error("end_pos: expected %0d, got %0d", want.end_pos, got.end_pos);
			mismatches++;
		end
		if (want.end_of_text !== got.end_of_text) begin
			$error("end_of_text: expected %0d, got %0d", want.end_of_text, got.end_of_text);
			mismatches++;
		end
		if (want.token_total !== got.token_total) begin
			$error("token_total: expected %0d, got %0d", want.token_total, got.token_total);
			mismatches++;
		end
	endtask

	task automatic send_byte(logic [7:0] b);
		int gap;
		gap = sender_idles ? $urandom_range(0, 14) : 0;
		if (gap > 0) begin
			text_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		text_ch.valid <= 1'b1;
		text_ch.text_byte <= b;
		do @(posedge clk); while (text_ch.ready !== 1'b1);
		tokenize_byte(b);
		bytes_sent++;
		if (b == CHAR_END)
			texts_sent++;
	endtask

	task automatic wait_until_drained();
		text_ch.valid <= 1'b0;
		while (expected_tokens.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_capacity(count_t value);
		wait_until_drained();
		cfg_ch.valid <= 1'b1;
		cfg_ch.token_capacity <= value;
		do @(posedge clk); while (cfg_ch.ready !== 1'b1);
		cfg_ch.valid <= 1'b0;
		capacity = value;
	endtask

	task automatic send_random_text();
		logic [7:0] text_q[$];
		int frags;
		int len;
		frags = $urandom_range(1, 8);
		for (int f = 0; f < frags; f++) begin
			case ($urandom_range(0, 9))
				0, 1: begin
					len = $urandom_range(1, 6);
					repeat (len) text_q.push_back(any_letter());
					if ($urandom_range(0, 2) == 0) begin
						text_q.push_back($urandom_range(0, 1) ? CHAR_APOS : CHAR_HYPHEN);
						text_q.push_back(any_letter());
					end
				end
				2: begin
					len = $urandom_range(1, 5);
					repeat (len) text_q.push_back(any_digit());
					if ($urandom_range(0, 2) == 0) begin
						text_q.push_back(CHAR_DOT);
						text_q.push_back(any_digit());
					end
				end
				3: begin
					len = $urandom_range(1, 4);
					repeat (len) text_q.push_back(any_space());
				end
				4: begin
					text_q.push_back(8'(CJK_LO + $urandom_range(0, 5)));
					len = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 1) : 2;
					repeat (len) text_q.push_back(8'($urandom_range(1, 255)));
				end
				5: begin
					if ($urandom_range(0, 1)) begin
						text_q.push_back(any_letter());
						text_q.push_back($urandom_range(0, 1) ? CHAR_APOS : CHAR_HYPHEN);
					end else begin
						text_q.push_back(any_digit());
						text_q.push_back(CHAR_DOT);
					end
					text_q.push_back(8'($urandom_range(1, 255)));
				end
				6: begin
					len = $urandom_range(1, 3);
					repeat (len)
						text_q.push_back($urandom_range(0, 1) ? any_letter() : any_digit());
					case ($urandom_range(0, 2))
						0: text_q.push_back(CHAR_APOS);
						1: text_q.push_back(CHAR_HYPHEN);
						default: text_q.push_back(CHAR_DOT);
					endcase
				end
				default: begin
					text_q.push_back(8'($urandom_range(1, 255)));
				end
			endcase
		end
		text_q.push_back(CHAR_END);
		foreach (text_q[i])
			send_byte(text_q[i]);
	endtask

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		result_t got;
		int stall;
		token_ch.ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			stall = receiver_idles ? $urandom_range(0, 14) : 0;
			if (stall > 0) begin
				token_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			token_ch.ready <= 1'b1;
			do @(posedge clk); while (token_ch.valid !== 1'b1);
			got.token_kind = token_ch.token_kind;
			got.start_pos = token_ch.start_pos;
			got.end_pos = token_ch.end_pos;
			got.end_of_text = token_ch.end_of_text;
			got.token_total = token_ch.token_total;
			if (expected_tokens.size() == 0) begin
				$error("Token transfer with no expectation: kind %0d, start %0d, end %0d",
					got.token_kind, got.start_pos, got.end_pos);
				mismatches++;
			end else begin
				check_token(expected_tokens.pop_front(), got);
				tokens_checked++;
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n) begin
			idle_cycles <= 0;
		end else if ((text_ch.valid && text_ch.ready) || (token_ch.valid && token_ch.ready)
				|| (cfg_ch.valid && cfg_ch.ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= IDLE_LIMIT) begin
			$display("Timeout after %0d cycles without a transfer", idle_cycles);
			$display("Mismatches found");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		count_t cap;
		int phase_start;
		arst_n <= 1'b0;
		text_ch.valid <= 1'b0;
		text_ch.text_byte <= 8'h00;
		cfg_ch.valid <= 1'b0;
		cfg_ch.token_capacity <= 16'h0000;
		capacity = CAPACITY_RESET;
		restart_text();
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i]) begin
			send_byte(directed_rows[i].text_byte);
			if (directed_rows[i].typed)
				check_token(directed_rows[i].last_token, expected_tokens[$]);
		end

		for (int p = 0; p < 8; p++) begin
			case (p)
				0: cap = 16'd0;
				1: cap = 16'd1;
				2: cap = 16'd2;
				3: cap = 16'($urandom_range(3, 8));
				4: cap = 16'hFFFF;
				5: cap = CAPACITY_RESET;
				6: cap = 16'($urandom_range(0, 65535));
				default: cap = 16'($urandom_range(4, 12));
			endcase
			write_capacity(cap);
			sender_idles = (p % 4 == 0) || (p % 4 == 1);
			receiver_idles = (p % 4 == 0) || (p % 4 == 2);
			phase_start = bytes_sent;
			while (bytes_sent - phase_start < PHASE_BYTES)
				send_random_text();
		end

		wait_until_drained();
		$display("Sent %0d text bytes in %0d texts and checked %0d token transfers,",
			bytes_sent, texts_sent, tokens_checked);
		$display("under capacities from 0 to 65535, with and without random idling.");
		if (mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

FILE: filelist.f
rtl/core/cct_pkg.sv
rtl/core/cct_byte_if.sv
rtl/core/cct_token_if.sv
rtl/core/cct_cfg_if.sv
rtl/core/cct_core.sv
rtl/core/cct_queue.sv
rtl/core/char_class_tokenizer_unit.sv
tb/sv/tb.sv
